// ===== hdl/sql_comment_literal_stripper_top_defines.svh =====
// ----------------------------------------------------------------------------
// SQL comment and literal stripper: assertion macros
// Concurrent assertion wrappers shared by the modules of the stripper.
// ----------------------------------------------------------------------------
`ifndef SQL_COMMENT_LITERAL_STRIPPER_TOP_DEFINES_SVH
`define SQL_COMMENT_LITERAL_STRIPPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed (same cycle)");
`define SCLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed (next cycle)");
`else
`define SCLS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCLS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/scls_pkg.sv =====
// ----------------------------------------------------------------------------
// SQL comment and literal stripper: package
// Character codes, lexer state types and the result item format.
// ----------------------------------------------------------------------------
package scls_pkg;

	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int MAX_RES     = 3;
	localparam int QUEUE_DEPTH = 8;

	typedef enum logic [2:0] {
		MODE_TEXT  = 3'd0,
		MODE_LINE  = 3'd1,
		MODE_BLOCK = 3'd2,
		MODE_STR   = 3'd3,
		MODE_ID    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		HELD_NONE  = 2'd0,
		HELD_DASH  = 2'd1,
		HELD_SLASH = 2'd2,
		HELD_STAR  = 2'd3
	} held_t;

	typedef struct packed {
		logic [7:0] data;
		logic       carries;
		logic       eot;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]          n;
		res_t [MAX_RES-1:0]  lanes;
	} push_t;

endpackage

// ===== hdl/scls_lexer.sv =====
// ----------------------------------------------------------------------------
// SQL comment and literal stripper: lexer
// Input register, lexer state and the results of one item, packed in order.
// ----------------------------------------------------------------------------
`include "sql_comment_literal_stripper_top_defines.svh"

module scls_lexer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     text_byte,
	input  logic           final_byte,
	input  logic           space,
	output scls_pkg::push_t push
);
	import scls_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	mode_t      mode_q;
	held_t      held_q;

	logic       proc;
	mode_t      mode_n;
	held_t      held_n;
	logic       rel_v;
	logic       cur_v;
	logic       end_v;
	logic       used;
	logic [7:0] rel_b;
	logic [7:0] cur_b;
	logic [1:0] n;
	res_t       r_rel;
	res_t       r_cur;
	res_t       r_end;
	res_t [MAX_RES-1:0] lanes;

	assign proc     = v_s1 && space;
	assign in_stall = v_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	always_comb begin
		mode_n = mode_q;
		held_n = HELD_NONE;
		rel_v  = 1'b0;
		cur_v  = 1'b0;
		used   = 1'b0;
		rel_b  = CH_DASH;
		cur_b  = byte_s1;
		if (held_q == HELD_DASH && mode_q == MODE_TEXT) begin
			if (byte_s1 == CH_DASH) begin
				mode_n = MODE_LINE;
				used   = 1'b1;
			end else begin
				rel_v = 1'b1;
			end
		end else if (held_q == HELD_SLASH && mode_q == MODE_TEXT) begin
			if (byte_s1 == CH_STAR) begin
				mode_n = MODE_BLOCK;
				used   = 1'b1;
			end else begin
				rel_v = 1'b1;
				rel_b = CH_SLASH;
			end
		end else if (held_q == HELD_STAR && mode_q == MODE_BLOCK) begin
			if (byte_s1 == CH_SLASH) begin
				mode_n = MODE_TEXT;
				used   = 1'b1;
			end
		end
		if (!used) begin
			case (mode_q)
				MODE_LINE: begin
					if (byte_s1 == CH_NL) begin
						mode_n = MODE_TEXT;
						cur_v  = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (byte_s1 == CH_STAR && !final_s1) begin
						held_n = HELD_STAR;
					end
				end
				MODE_STR: begin
					cur_v = 1'b1;
					cur_b = CH_SPACE;
					if (byte_s1 == CH_SQUOTE) begin
						mode_n = MODE_TEXT;
					end
				end
				MODE_ID: begin
					cur_v = 1'b1;
					if (byte_s1 == CH_DQUOTE) begin
						mode_n = MODE_TEXT;
					end
				end
				default: begin
					mode_n = MODE_TEXT;
					if ((byte_s1 == CH_DASH || byte_s1 == CH_SLASH) && !final_s1) begin
						held_n = (byte_s1 == CH_DASH) ? HELD_DASH : HELD_SLASH;
					end else if (byte_s1 == CH_SQUOTE) begin
						mode_n = MODE_STR;
						cur_v  = 1'b1;
						cur_b  = CH_SPACE;
					end else begin
						if (byte_s1 == CH_DQUOTE) begin
							mode_n = MODE_ID;
						end
						cur_v = 1'b1;
					end
				end
			endcase
		end
		end_v = final_s1;
		if (final_s1) begin
			mode_n = MODE_TEXT;
			held_n = HELD_NONE;
		end
	end

	always_comb begin
		n = 2'(rel_v) + 2'(cur_v) + 2'(end_v);
		r_rel = '{data: rel_b, carries: 1'b1, eot: 1'b0, last: 1'b0};
		r_cur = '{data: cur_b, carries: 1'b1, eot: 1'b0, last: 1'b0};
		r_end = '{data: 8'd0, carries: 1'b0, eot: 1'b1, last: 1'b0};
		lanes[0] = rel_v ? r_rel : (cur_v ? r_cur : r_end);
		lanes[1] = (rel_v && cur_v) ? r_cur : r_end;
		lanes[2] = r_end;
		for (int i = 0; i < MAX_RES; i++) begin
			lanes[i].last = (n == 2'(i + 1));
		end
		push.n     = proc ? n : 2'd0;
		push.lanes = lanes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			held_q <= HELD_NONE;
		end else if (proc) begin
			mode_q <= mode_n;
			held_q <= held_n;
		end
	end

	`SCLS_ASSERT_IMP(a_held_pair, clk, arst_n,
		held_q == HELD_DASH || held_q == HELD_SLASH, mode_q == MODE_TEXT)
	`SCLS_ASSERT_IMP(a_held_star, clk, arst_n, held_q == HELD_STAR, mode_q == MODE_BLOCK)
	`SCLS_ASSERT_NXT(a_final_reset, clk, arst_n, proc && final_s1,
		mode_q == MODE_TEXT && held_q == HELD_NONE)

endmodule

// ===== hdl/scls_outq.sv =====
// ----------------------------------------------------------------------------
// SQL comment and literal stripper: result queue
// Small register queue that takes up to three result items per cycle and
// presents one item per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
`include "sql_comment_literal_stripper_top_defines.svh"

module scls_outq #(
	parameter int DEPTH = scls_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  scls_pkg::push_t push,
	output logic            space,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            carries_byte,
	output logic            end_of_text,
	output logic            run_last
);
	import scls_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	res_t             head;

	assign space     = (count_q <= CNT_W'(DEPTH - MAX_RES));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];

	assign out_byte     = head.data;
	assign carries_byte = head.carries;
	assign end_of_text  = head.eot;
	assign run_last     = head.last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (push.n > 2'(i)) begin
				mem_q[wr_ptr_q + PTR_W'(i)] <= push.lanes[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`SCLS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`SCLS_ASSERT_IMP(a_no_overflow, clk, arst_n, push.n != 2'd0,
		count_q <= CNT_W'(DEPTH - MAX_RES))
	`SCLS_ASSERT_NXT(a_pop_only, clk, arst_n, pop && push.n == 2'd0,
		count_q == $past(count_q) - CNT_W'(1))

endmodule

// ===== hdl/sql_comment_literal_stripper_top.sv =====
// ----------------------------------------------------------------------------
// SQL comment and literal stripper: top level
// Removes SQL comments and blanks string literals, one text byte per item.
// ----------------------------------------------------------------------------
// The input channel takes one byte of query text per item, with final_byte
// set on the last byte of a query. The output channel gives the cleaned text
// as result items; after the final byte an end marker item follows, and
// run_last marks the last result item that an input item causes.
// Both channels use valid and stall, and an item moves when valid is high and
// stall is low.
// An input item is registered on acceptance and lexed once the result queue
// has room; its results are written into that small queue. One input item can
// be accepted every cycle while the queue has room; each gives zero to three
// result items, and the output drains one item per cycle unless stalled.
// The input stalls only while the result queue lacks room for three items,
// which can happen when results arrive faster than the output drains them.
// Reset clears the queue and returns the lexer to plain text with no byte
// held back.
// The queue depth must be a power of two and at least four.

module sql_comment_literal_stripper_top #(
	parameter int QUEUE_DEPTH = scls_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       carries_byte,
	output logic       end_of_text,
	output logic       run_last
);
	import scls_pkg::*;

	push_t push;
	logic  space;

	scls_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.space      (space),
		.push       (push)
	);

	scls_outq #(
		.DEPTH (QUEUE_DEPTH)
	) u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space        (space),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.carries_byte (carries_byte),
		.end_of_text  (end_of_text),
		.run_last     (run_last)
	);

endmodule
